// ===== src/aes128ke_pkg.sv =====
// Shared constants and lookup functions for the AES-128 key expansion core.
package aes128ke_pkg;

  localparam int unsigned KeyWidth = 128;
  localparam int unsigned HalfWidth = 64;
  localparam int unsigned RoundWidth = 4;
  localparam logic [RoundWidth-1:0] LastRound = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundWidth-1:0] round);
    logic [7:0] c;
    case (round)
      4'd1:    c = 8'h01;
      4'd2:    c = 8'h02;
      4'd3:    c = 8'h04;
      4'd4:    c = 8'h08;
      4'd5:    c = 8'h10;
      4'd6:    c = 8'h20;
      4'd7:    c = 8'h40;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h1b;
      4'd10:   c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/aes128ke_round.sv =====
// One step of the AES-128 key schedule: derives a round key from the previous one.
module aes128ke_round (
  input  logic [aes128ke_pkg::KeyWidth-1:0]   prev_key,
  input  logic [aes128ke_pkg::RoundWidth-1:0] round,
  output logic [aes128ke_pkg::KeyWidth-1:0]   next_key
);

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] core;
  logic [31:0] n0, n1, n2, n3;

  always_comb begin
    w0 = prev_key[127:96];
    w1 = prev_key[95:64];
    w2 = prev_key[63:32];
    w3 = prev_key[31:0];
    core = {aes128ke_pkg::sbox(w3[23:16]) ^ aes128ke_pkg::rcon(round),
            aes128ke_pkg::sbox(w3[15:8]),
            aes128ke_pkg::sbox(w3[7:0]),
            aes128ke_pkg::sbox(w3[31:24])};
    n0 = w0 ^ core;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    next_key = {n0, n1, n2, n3};
  end

endmodule

// ===== src/aes128_key_expansion_core.sv =====
// Top level of the AES-128 key expansion core: input holding register and round key register.
// Round key 0 passes the input holding register, then the round key register; after it, one
// round key per cycle while out_stall is low. The single round unit builds each round key
// from the one held in the result register; the next key waits in the input register.
// Reset (rst_n low, synchronous) clears both valid flags; payload registers are not reset.
module aes128_key_expansion_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [aes128ke_pkg::HalfWidth-1:0]      in_key_high,
  input  logic [aes128ke_pkg::HalfWidth-1:0]      in_key_low,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [aes128ke_pkg::RoundWidth-1:0]     out_round_index,
  output logic [aes128ke_pkg::HalfWidth-1:0]      out_round_key_high,
  output logic [aes128ke_pkg::HalfWidth-1:0]      out_round_key_low,
  output logic                                    out_last_round
);

  logic                                    hold_valid_r, hold_valid_nxt;
  logic [aes128ke_pkg::KeyWidth-1:0]       hold_key_r, hold_key_nxt;
  logic                                    res_valid_r, res_valid_nxt;
  logic [aes128ke_pkg::RoundWidth-1:0]     res_round_r, res_round_nxt;
  logic [aes128ke_pkg::KeyWidth-1:0]       res_key_r, res_key_nxt;
  logic [aes128ke_pkg::RoundWidth-1:0]     step_round;
  logic [aes128ke_pkg::KeyWidth-1:0]       step_key;
  logic                                    res_last;
  logic                                    res_advance;

  assign step_round = res_round_r + 4'd1;
  assign res_last = (res_round_r == aes128ke_pkg::LastRound);

  aes128ke_round u_round (
    .prev_key (res_key_r),
    .round    (step_round),
    .next_key (step_key)
  );

  assign in_stall = hold_valid_r;
  assign res_advance = !res_valid_r || !out_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_key_nxt = hold_key_r;
    res_valid_nxt = res_valid_r;
    res_round_nxt = res_round_r;
    res_key_nxt = res_key_r;
    if (res_advance) begin
      if (res_valid_r && !res_last) begin
        res_round_nxt = step_round;
        res_key_nxt = step_key;
      end else if (hold_valid_r) begin
        res_valid_nxt = 1'b1;
        res_round_nxt = '0;
        res_key_nxt = hold_key_r;
        hold_valid_nxt = 1'b0;
      end else begin
        res_valid_nxt = 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      hold_valid_nxt = 1'b1;
      hold_key_nxt = {in_key_high, in_key_low};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_key_r <= hold_key_nxt;
    res_round_r <= res_round_nxt;
    res_key_r <= res_key_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_round_index = res_round_r;
  assign out_round_key_high = res_key_r[127:64];
  assign out_round_key_low = res_key_r[63:0];
  assign out_last_round = res_last;

endmodule

// ===== dv/tb_aes128_key_expansion_core.sv =====
// Self-checking testbench for the AES-128 key expansion core: directed keys, then random keys.
module tb_aes128_key_expansion_core;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainPad = 20;
  localparam int NumRows = 12;
  localparam int KeysPerPhase = 84;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [aes128ke_pkg::RoundWidth-1:0] idx;
    logic [aes128ke_pkg::HalfWidth-1:0]  hi;
    logic [aes128ke_pkg::HalfWidth-1:0]  lo;
    logic                                last;
  } round_key_t;

  typedef struct packed {
    logic [aes128ke_pkg::HalfWidth-1:0] key_hi;
    logic [aes128ke_pkg::HalfWidth-1:0] key_lo;
    logic                               has_last;
    logic [aes128ke_pkg::HalfWidth-1:0] last_hi;
    logic [aes128ke_pkg::HalfWidth-1:0] last_lo;
  } key_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [aes128ke_pkg::HalfWidth-1:0] in_key_high = '0;
  logic [aes128ke_pkg::HalfWidth-1:0] in_key_low = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [aes128ke_pkg::RoundWidth-1:0] out_round_index;
  logic [aes128ke_pkg::HalfWidth-1:0] out_round_key_high;
  logic [aes128ke_pkg::HalfWidth-1:0] out_round_key_low;
  logic out_last_round;

  round_key_t round_keys_due [$];
  int error_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic long_hold = 1'b0;
  event hold_start;

  // Rows with a typed last round key carry well-known published schedules.
  key_row_t key_table [NumRows] = '{
    {64'h0000000000000000, 64'h0000000000000000, 1'b1,
     64'hb4ef5bcb3e92e211, 64'h23e951cf6f8f188e},
    {64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
     64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6},
    {64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
     64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5},
    {64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    {64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 64'h0, 64'h0},
    {64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    {64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 1'b0, 64'h0, 64'h0},
    {64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
    {64'h0000000000000001, 64'h8000000000000000, 1'b0, 64'h0, 64'h0},
    {64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
    {64'h0000000000000000, 64'h00000000ff000000, 1'b0, 64'h0, 64'h0},
    {64'h0000000000000000, 64'h0000000000000000, 1'b1,
     64'hb4ef5bcb3e92e211, 64'h23e951cf6f8f188e}
  };

  aes128_key_expansion_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_round_index    (out_round_index),
    .out_round_key_high (out_round_key_high),
    .out_round_key_low  (out_round_key_low),
    .out_last_round     (out_last_round)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The S-box is the field inverse, by raising to the power 254, then the affine map.
  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    logic [7:0] sq;
    logic [7:0] inv;
    sq = b;
    inv = 8'h01;
    for (int i = 0; i < 7; i++) begin
      sq = gf_mul(sq, sq);
      inv = gf_mul(inv, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic void expand_cipher_key(input key_row_t row);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [7:0] rc;
    round_key_t rk;
    w[0] = row.key_hi[63:32];
    w[1] = row.key_hi[31:0];
    w[2] = row.key_lo[63:32];
    w[3] = row.key_lo[31:0];
    rc = 8'h01;
    for (int r = 0; r <= int'(aes128ke_pkg::LastRound); r++) begin
      if (r != 0) begin
        t = {sub_byte(w[3][23:16]) ^ rc, sub_byte(w[3][15:8]), sub_byte(w[3][7:0]),
             sub_byte(w[3][31:24])};
        rc = gf_mul(rc, 8'h02);
        w[0] ^= t;
        w[1] ^= w[0];
        w[2] ^= w[1];
        w[3] ^= w[2];
      end
      rk.idx = r[aes128ke_pkg::RoundWidth-1:0];
      rk.hi = {w[0], w[1]};
      rk.lo = {w[2], w[3]};
      rk.last = (rk.idx == aes128ke_pkg::LastRound);
      if (rk.last && row.has_last) begin
        rk.hi = row.last_hi;
        rk.lo = row.last_lo;
      end
      round_keys_due.push_back(rk);
    end
  endfunction

  task automatic send_key(input key_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_high <= row.key_hi;
    in_key_low <= row.key_lo;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expand_cipher_key(row);
  endtask

  task automatic wait_all_round_keys();
    in_valid <= 1'b0;
    while (round_keys_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial forever begin
    @(hold_start);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin : check_round_keys
    round_key_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (round_keys_due.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MaxReports)
          $display("unexpected round key: idx %0d key %h_%h last %b", out_round_index,
                   out_round_key_high, out_round_key_low, out_last_round);
      end else begin
        want = round_keys_due.pop_front();
        if (out_round_index !== want.idx || out_round_key_high !== want.hi ||
            out_round_key_low !== want.lo || out_last_round !== want.last) begin
          error_cnt++;
          if (error_cnt <= MaxReports)
            $display("mismatch: exp idx %0d key %h_%h last %b, got idx %0d key %h_%h last %b",
                     want.idx, want.hi, want.lo, want.last, out_round_index,
                     out_round_key_high, out_round_key_low, out_last_round);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_aes128_key_expansion_core NOT OK");
      $finish;
    end
  end

  initial begin
    key_row_t row;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumRows; i++) send_key(key_table[i]);
    wait_all_round_keys();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < KeysPerPhase; n++) begin
        if (phase == 0 && n == 20) -> hold_start;
        row = '0;
        row.key_hi = {$urandom(), $urandom()};
        row.key_lo = {$urandom(), $urandom()};
        send_key(row);
        if (n == 40) wait_all_round_keys();
      end
      wait_all_round_keys();
    end
    repeat (DrainPad) @(posedge clk);
    if (error_cnt == 0) begin
      $display("tb_aes128_key_expansion_core OK");
    end else begin
      $display("tb_aes128_key_expansion_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/aes128ke_pkg.sv
src/aes128ke_round.sv
src/aes128_key_expansion_core.sv
dv/tb_aes128_key_expansion_core.sv
